// ----- rtl/core/imu_wsd_pkg.sv -----
package imu_wsd_pkg;

  localparam int WIN_LOG2     = 4;
  localparam int WIN_DEPTH    = 1 << WIN_LOG2;
  localparam int SMP_W        = 16;
  localparam int N_AXES       = 3;
  localparam int IN_DATA_W    = 9 * SMP_W;
  localparam int RING_W       = 6 * SMP_W;
  localparam int SUM_W        = SMP_W + WIN_LOG2;
  localparam int SQ1_W        = 2 * SMP_W - 1;
  localparam int SQ_W         = SQ1_W + WIN_LOG2;
  localparam int NUM_W        = SQ_W + WIN_LOG2;
  localparam int PROD_W       = 2 * SUM_W;
  localparam int DIFF_W       = ((NUM_W > PROD_W) ? NUM_W : PROD_W) + 1;
  localparam int VAR_DIV      = WIN_DEPTH * (WIN_DEPTH - 1);
  localparam int DIV_W        = 2 * WIN_LOG2;
  localparam int ROOT_W       = 16;
  localparam int ROOT_K_W     = $clog2(ROOT_W);
  localparam int TR_W         = DIV_W + 2 * ROOT_W + 1;
  localparam int DS_W         = DIV_W + ROOT_W + 1;
  localparam int TOT_W        = ROOT_W + 2;
  localparam int CMP_W        = TOT_W + 4;
  localparam int THR_W        = 18;
  localparam int THR_RESET    = 100;
  localparam int STILL_DIV    = 10;
  localparam int PHASE_PERIOD = 20;
  localparam int PHASE_W      = $clog2(PHASE_PERIOD);
  localparam int ACCEL_PHASE  = 19;
  localparam int MAG_PHASE    = 17;
  localparam int OUT_DATA_W   = 56;
  localparam int KIND_W       = 2;
  localparam int AXIS_W       = 2;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEL     = 2'd0,
    KIND_MAG       = 2'd1,
    KIND_ZERO_RATE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQN,
    ST_FILL,
    ST_SQO,
    ST_UPD,
    ST_MUL,
    ST_NUM,
    ST_ROOT,
    ST_CMP,
    ST_EMIT_M,
    ST_EMIT_Z
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
  } root_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_sts_t;

endpackage

// ----- rtl/core/imu_window_stillness_detector_top.sv -----
// Channel | Direction | Ports                               | Contents
// in      | slave     | in_tvalid, in_tready, in_tdata      | one IMU sample set
// out     | master    | out_tvalid, out_tready, out_tdata,  | window means or a
//         |           | out_tuser, out_tlast                | zero-rate request
// cfg     | write     | cfg_wr_en, cfg_wr_data              | stillness threshold
//
// The first transaction after reset takes three squaring steps and a window fill that writes
// its sample into all 16 window entries, and the next transaction is accepted once the fill is done.
// Every later transaction takes seven squaring and update steps, then for each accel axis
// a squaring step, a numerator step and a wait on the shared square-root unit, then one
// compare step and one emit step per result.
// Reset is synchronous and active low; the window holds no data until the
// first transaction has filled it.
// Results wait in the output register; the sequencer holds while it is full,
// and a new transaction is taken once the sequencer is idle again.
module imu_window_stillness_detector_top
  import imu_wsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z, rate_x, rate_y, rate_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // value_x, value_y, value_z, rate_axis, zero padding
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic [KIND_W-1:0]     out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [THR_W-1:0]      cfg_wr_data
);

  seq_state_t state_r, state_nxt;

  logic signed [SMP_W-1:0] acc_r  [N_AXES];
  logic signed [SMP_W-1:0] acc_nxt [N_AXES];
  logic signed [SMP_W-1:0] mag_r  [N_AXES];
  logic signed [SMP_W-1:0] mag_nxt [N_AXES];
  logic signed [SMP_W-1:0] rate_r [N_AXES];
  logic signed [SMP_W-1:0] rate_nxt [N_AXES];
  logic signed [SUM_W-1:0] asum_r [N_AXES];
  logic signed [SUM_W-1:0] asum_nxt [N_AXES];
  logic signed [SUM_W-1:0] msum_r [N_AXES];
  logic signed [SUM_W-1:0] msum_nxt [N_AXES];
  logic [SQ_W-1:0]         sq_r [N_AXES];
  logic [SQ_W-1:0]         sq_nxt [N_AXES];
  logic [SQ1_W-1:0]        nsq_r [N_AXES];
  logic [SQ1_W-1:0]        nsq_nxt [N_AXES];
  logic [SQ1_W-1:0]        osq_r [N_AXES];
  logic [SQ1_W-1:0]        osq_nxt [N_AXES];

  logic [1:0]              ax_r, ax_nxt;
  logic [WIN_LOG2-1:0]     idx_r, idx_nxt;
  logic [WIN_LOG2-1:0]     pos_r, pos_nxt;
  logic [PHASE_W-1:0]      phase_r, phase_nxt;
  logic [1:0]              turn_r, turn_nxt;
  logic                    primed_r, primed_nxt;
  logic                    still_r, still_nxt;
  kind_t                   mkind_r, mkind_nxt;
  logic [TOT_W-1:0]        tot_r, tot_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [THR_W-1:0]        thr_r, thr_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [KIND_W-1:0]       out_user_r, out_user_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    ram_we;
  logic [WIN_LOG2-1:0]     ram_waddr;
  logic [RING_W-1:0]       ram_wdata;
  logic [RING_W-1:0]       ram_rdata;

  logic signed [SUM_W-1:0]  mul_a;
  logic signed [PROD_W-1:0] mul_p;
  logic [NUM_W-1:0]         sq_scaled;
  logic signed [DIFF_W-1:0] diff;
  logic                     out_free;
  logic [AXIS_W-1:0]        zr_axis;
  logic signed [SMP_W-1:0]  zr_rate;

  root_req_t root_req;
  root_sts_t root_sts;

  function automatic logic [SMP_W-1:0] round_mean(input logic signed [SUM_W-1:0] s);
    logic [SUM_W:0] mag;
    logic [SUM_W:0] q;
    mag = s[SUM_W-1] ? ((SUM_W+1)'(0) - {s[SUM_W-1], s}) : {1'b0, s};
    q   = (mag + (SUM_W+1)'(WIN_DEPTH / 2)) >> WIN_LOG2;
    return s[SUM_W-1] ? (SMP_W'(0) - q[SMP_W-1:0]) : q[SMP_W-1:0];
  endfunction

  imu_wsd_ram #(
    .WIDTH (RING_W),
    .DEPTH (WIN_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (pos_r),
    .rd_data (ram_rdata)
  );

  imu_wsd_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (root_req),
    .sts   (root_sts)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign ram_wdata = {mag_r[2], mag_r[1], mag_r[0], acc_r[2], acc_r[1], acc_r[0]};

  always_comb begin
    case (turn_r)
      2'd0:    zr_axis = AXIS_X;
      2'd1:    zr_axis = AXIS_Z;
      default: zr_axis = AXIS_Y;
    endcase
    zr_rate = rate_r[zr_axis];
  end

  always_comb begin
    case (state_r)
      ST_SQN:  mul_a = SUM_W'(acc_r[ax_r]);
      ST_SQO:  mul_a = SUM_W'($signed(ram_rdata[ax_r*SMP_W +: SMP_W]));
      default: mul_a = asum_r[ax_r];
    endcase
    mul_p     = mul_a * mul_a;
    sq_scaled = {sq_r[ax_r], {WIN_LOG2{1'b0}}};
    diff      = $signed(DIFF_W'(sq_scaled)) - DIFF_W'(prod_r);
  end

  assign root_req.start = (state_r == ST_NUM);
  assign root_req.num   = diff[DIFF_W-1] ? '0 : diff[NUM_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    mag_nxt       = mag_r;
    rate_nxt      = rate_r;
    asum_nxt      = asum_r;
    msum_nxt      = msum_r;
    sq_nxt        = sq_r;
    nsq_nxt       = nsq_r;
    osq_nxt       = osq_r;
    ax_nxt        = ax_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    turn_nxt      = turn_r;
    primed_nxt    = primed_r;
    still_nxt     = still_r;
    mkind_nxt     = mkind_r;
    tot_nxt       = tot_r;
    prod_nxt      = prod_r;
    thr_nxt       = cfg_wr_en ? cfg_wr_data : thr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    in_tready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          for (int a = 0; a < N_AXES; a++) begin
            acc_nxt[a]  = $signed(in_tdata[a*SMP_W +: SMP_W]);
            mag_nxt[a]  = $signed(in_tdata[(N_AXES+a)*SMP_W +: SMP_W]);
            rate_nxt[a] = $signed(in_tdata[(2*N_AXES+a)*SMP_W +: SMP_W]);
          end
          ax_nxt    = '0;
          state_nxt = ST_SQN;
        end
      end
      ST_SQN: begin
        nsq_nxt[ax_r] = mul_p[SQ1_W-1:0];
        if (ax_r == 2'd2) begin
          ax_nxt    = '0;
          idx_nxt   = '0;
          state_nxt = primed_r ? ST_SQO : ST_FILL;
        end else begin
          ax_nxt = ax_r + 1'b1;
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        if (idx_r == '0) begin
          for (int a = 0; a < N_AXES; a++) begin
            asum_nxt[a] = SUM_W'(acc_r[a]) <<< WIN_LOG2;
            msum_nxt[a] = SUM_W'(mag_r[a]) <<< WIN_LOG2;
            sq_nxt[a]   = SQ_W'(nsq_r[a]) << WIN_LOG2;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == WIN_LOG2'(WIN_DEPTH - 1)) begin
          primed_nxt = 1'b1;
          pos_nxt    = '0;
          state_nxt  = ST_IDLE;
        end
      end
      ST_SQO: begin
        osq_nxt[ax_r] = mul_p[SQ1_W-1:0];
        if (ax_r == 2'd2) begin
          ax_nxt    = '0;
          state_nxt = ST_UPD;
        end else begin
          ax_nxt = ax_r + 1'b1;
        end
      end
      ST_UPD: begin
        ram_we = 1'b1;
        for (int a = 0; a < N_AXES; a++) begin
          asum_nxt[a] = asum_r[a] + SUM_W'(acc_r[a])
                      - SUM_W'($signed(ram_rdata[a*SMP_W +: SMP_W]));
          msum_nxt[a] = msum_r[a] + SUM_W'(mag_r[a])
                      - SUM_W'($signed(ram_rdata[(N_AXES+a)*SMP_W +: SMP_W]));
          sq_nxt[a]   = sq_r[a] + SQ_W'(nsq_r[a]) - SQ_W'(osq_r[a]);
        end
        pos_nxt   = pos_r + 1'b1;
        ax_nxt    = '0;
        tot_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = ST_NUM;
      end
      ST_NUM: begin
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_sts.done) begin
          tot_nxt = tot_r + TOT_W'(root_sts.root);
          if (ax_r == 2'd2) begin
            state_nxt = ST_CMP;
          end else begin
            ax_nxt    = ax_r + 1'b1;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_CMP: begin
        still_nxt = (CMP_W'(tot_r) * CMP_W'(STILL_DIV)) < CMP_W'(thr_r);
        mkind_nxt = (phase_r == PHASE_W'(ACCEL_PHASE)) ? KIND_ACCEL : KIND_MAG;
        phase_nxt = (phase_r == PHASE_W'(PHASE_PERIOD - 1)) ? '0 : phase_r + 1'b1;
        if (phase_r == PHASE_W'(ACCEL_PHASE) || phase_r == PHASE_W'(MAG_PHASE)) begin
          state_nxt = ST_EMIT_M;
        end else if (still_nxt) begin
          state_nxt = ST_EMIT_Z;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_M: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = mkind_r;
          out_last_nxt  = !still_r;
          if (mkind_r == KIND_ACCEL) begin
            out_data_nxt = {8'd0, round_mean(asum_r[2]), round_mean(asum_r[1]),
                            round_mean(asum_r[0])};
          end else begin
            out_data_nxt = {8'd0, round_mean(msum_r[2]), round_mean(msum_r[1]),
                            round_mean(msum_r[0])};
          end
          state_nxt = still_r ? ST_EMIT_Z : ST_IDLE;
        end
      end
      ST_EMIT_Z: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = KIND_ZERO_RATE;
          out_last_nxt  = 1'b1;
          out_data_nxt  = {6'd0, zr_axis, {(2*SMP_W){1'b0}}, zr_rate};
          turn_nxt      = (turn_r == 2'd2) ? 2'd0 : turn_r + 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      phase_r     <= '0;
      turn_r      <= '0;
      primed_r    <= 1'b0;
      thr_r       <= THR_W'(THR_RESET);
      out_valid_r <= 1'b0;
      ax_r        <= '0;
      idx_r       <= '0;
    end else begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      turn_r      <= turn_nxt;
      primed_r    <= primed_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
      ax_r        <= ax_nxt;
      idx_r       <= idx_nxt;
    end
    acc_r      <= acc_nxt;
    mag_r      <= mag_nxt;
    rate_r     <= rate_nxt;
    asum_r     <= asum_nxt;
    msum_r     <= msum_nxt;
    sq_r       <= sq_nxt;
    nsq_r      <= nsq_nxt;
    osq_r      <= osq_nxt;
    still_r    <= still_nxt;
    mkind_r    <= mkind_nxt;
    tot_r      <= tot_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < PHASE_W'(PHASE_PERIOD))
    else $error("phase count left its period");

  a_root_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (root_sts.busy || root_sts.done) |-> (state_r == ST_ROOT))
    else $error("square-root unit active outside its sequencer step");

  a_fill_unprimed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> !primed_r)
    else $error("window fill after the window was primed");

  a_zero_rate_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r == KIND_ZERO_RATE) |->
      (out_data_r[2*SMP_W-1:SMP_W] == '0 && out_data_r[49:48] != 2'd3 && out_last_r))
    else $error("malformed zero-rate transaction");

  a_mean_no_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r != KIND_ZERO_RATE) |-> (out_data_r[49:48] == AXIS_X))
    else $error("means transaction carries an axis");

endmodule

// ----- rtl/core/imu_wsd_ram.sv -----
module imu_wsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/imu_wsd_root.sv -----
// Finds the largest root s with VAR_DIV * s * s <= num, one bit per cycle.
module imu_wsd_root
  import imu_wsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  root_req_t req,
  output root_sts_t sts
);

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [ROOT_K_W-1:0] k_r, k_nxt;
  logic [ROOT_W-1:0]   s_r, s_nxt;
  logic [DS_W-1:0]     ds_r, ds_nxt;
  logic [TR_W-1:0]     ds2_r, ds2_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [TR_W-1:0]     trial;

  always_comb begin
    trial = ds2_r
          + (TR_W'(ds_r) << ({1'b0, k_r} + 1'b1))
          + (TR_W'(VAR_DIV) << {k_r, 1'b0});
    run_nxt  = run_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    s_nxt    = s_r;
    ds_nxt   = ds_r;
    ds2_nxt  = ds2_r;
    num_nxt  = num_r;
    if (run_r) begin
      if (trial <= TR_W'(num_r)) begin
        ds2_nxt     = trial;
        ds_nxt      = ds_r + (DS_W'(VAR_DIV) << k_r);
        s_nxt[k_r]  = 1'b1;
      end
      if (k_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end else if (req.start) begin
      run_nxt = 1'b1;
      k_nxt   = ROOT_K_W'(ROOT_W - 1);
      s_nxt   = '0;
      ds_nxt  = '0;
      ds2_nxt = '0;
      num_nxt = req.num;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    k_r   <= k_nxt;
    s_r   <= s_nxt;
    ds_r  <= ds_nxt;
    ds2_r <= ds2_nxt;
    num_r <= num_nxt;
  end

  assign sts.busy = run_r;
  assign sts.done = done_r;
  assign sts.root = s_r;

endmodule
